// ----- rtl/cadf_pkg.sv -----
package cadf_pkg;

  localparam int unsigned MAX_STAGES_DEF   = 52;
  localparam int unsigned SAMPLE_WIDTH_DEF = 24;
  localparam int unsigned EXTRA_BITS       = 8;
  localparam int unsigned PHASE_BITS       = 16;

  localparam int unsigned STAGE_COUNT_W = 6;
  localparam int unsigned BLEND_W       = 16;
  localparam int unsigned RATE_W        = 17;
  localparam int unsigned CFG_DATA_W    = 17;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STAGE_COUNT = 2'd0,
    REG_BLEND       = 2'd1,
    REG_RATE_STEP   = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG,
    ST_BMUL,
    ST_BADD,
    ST_CASC,
    ST_POINTS,
    ST_IDIF,
    ST_IMUL,
    ST_IADD,
    ST_DONE
  } cadf_state_e;

endpackage

// ----- rtl/cadf_if.sv -----
interface cadf_in_if import cadf_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface cadf_out_if import cadf_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- rtl/cascaded_averaging_distance_filter.sv -----
// Channel | Dir | Payload               | Beat taken when
// --------+-----+-----------------------+-----------------------------
// in_i    | in  | sample_in  (Q1.23)    | in_i.valid & in_i.ready
// out_o   | out | sample_out (Q1.23)    | out_o.valid & out_o.ready
// cfg     | in  | cfg_idx_i/cfg_data_i  | cfg_we_i
//
// Sequence: one beat per item. Without a tick an item runs IDIF, IMUL, IADD,
//   DONE; with a tick AVG, BMUL, BADD, CASC over each active stage in the stage
//   memory (at most MAX_STAGES, one per cycle), POINTS, IDIF, IMUL, IADD, DONE.
// Ready is high only in IDLE; one multiplier serves both the blend and the
//   interpolation, one adder the cascade.
// The output register lets the next item enter while a result waits; the
//   sequencer stalls in DONE until that register is free.
// Reset (async, active low) clears control and filter state; the stage memory
//   needs no clearing since a stage is always preloaded before it is read.
module cascaded_averaging_distance_filter import cadf_pkg::*; #(
  parameter int unsigned MAX_STAGES   = MAX_STAGES_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  cadf_in_if.sink               in_i,
  cadf_out_if.source            out_o
);

  localparam int unsigned IW = SAMPLE_WIDTH + EXTRA_BITS;  // internal value width
  localparam int unsigned DW = IW + 1;                     // difference / sum width
  localparam int unsigned PW = DW + BLEND_W + 1;           // product width
  localparam int unsigned NW = $clog2(MAX_STAGES + 1);     // stage count width
  localparam int unsigned AW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int unsigned SW = SAMPLE_WIDTH;

  // configuration registers
  logic [STAGE_COUNT_W-1:0] stage_count_q;
  logic [BLEND_W-1:0]       blend_q;
  logic [RATE_W-1:0]        rate_q;

  // filter state
  logic [PHASE_BITS-1:0]  phase_q;
  logic signed [IW-1:0]   fa_q;       // first-stage average
  logic signed [IW-1:0]   older_q;
  logic signed [IW-1:0]   newer_q;
  logic [NW-1:0]          hl_q;       // highest stage count preloaded

  // working registers
  cadf_state_e            state_q, state_d;
  logic signed [IW-1:0]   x_q;
  logic signed [IW-1:0]   blend_val_q;
  logic signed [DW-1:0]   opa_q;
  logic [PHASE_BITS-1:0]  opb_q;
  logic signed [PW-1:0]   prod_q;
  logic [AW-1:0]          idx_q;
  logic signed [IW-1:0]   rd_q;

  logic                   out_valid_q;
  logic signed [SW-1:0]   out_data_q;

  // stage memory
  logic [IW-1:0] stage_mem [MAX_STAGES];

  // combinational
  logic [NW-1:0]          n_w;
  logic [RATE_W:0]        ph_sum_w;
  logic                   tick_w;
  logic                   accept_w;
  logic                   out_free_w;
  logic signed [DW-1:0]   avg_sum_w;
  logic signed [IW-1:0]   avg_w;
  logic signed [PW-1:0]   prod_w;
  logic signed [IW-1:0]   madd_base_w;
  logic signed [DW:0]     madd_sum_w;
  logic signed [IW-1:0]   madd_w;
  logic signed [IW-1:0]   cas_op_w;
  logic signed [DW-1:0]   cas_sum_w;
  logic signed [IW-1:0]   cas_w;
  logic signed [DW-1:0]   rnd_w;
  logic signed [SW:0]     rq_w;
  logic signed [SW-1:0]   sat_w;
  logic                   in_ready_w;
  logic                   mem_we_w;
  logic [AW-1:0]          rd_addr_w;

  assign n_w = (7'(stage_count_q) > 7'(MAX_STAGES)) ? NW'(MAX_STAGES) : NW'(stage_count_q);

  assign ph_sum_w = {2'b00, phase_q} + {1'b0, rate_q};
  assign tick_w   = |ph_sum_w[RATE_W:PHASE_BITS];

  assign accept_w   = in_i.valid & in_ready_w;
  assign out_free_w = ~out_valid_q | out_o.ready;

  // first-stage half average (floor)
  assign avg_sum_w = {x_q[IW-1], x_q} + {fa_q[IW-1], fa_q};
  assign avg_w     = avg_sum_w[DW-1:1];

  // shared multiplier: signed difference times unsigned Q0.16 weight
  assign prod_w = opa_q * $signed({1'b0, opb_q});

  // base + floor(product / 65536)
  assign madd_base_w = (state_q == ST_BADD) ? x_q : older_q;
  assign madd_sum_w  = {{2{madd_base_w[IW-1]}}, madd_base_w} + prod_q[PW-1:PHASE_BITS];
  assign madd_w      = madd_sum_w[IW-1:0];

  // cascade stage: stages at or above the preload mark read as the blended sample
  assign cas_op_w  = (NW'(idx_q) >= hl_q) ? blend_val_q : rd_q;
  assign cas_sum_w = {x_q[IW-1], x_q} + {cas_op_w[IW-1], cas_op_w};
  assign cas_w     = cas_sum_w[DW-1:1];

  // round back to sample format and saturate
  assign rnd_w = {x_q[IW-1], x_q} + DW'(1 << (EXTRA_BITS - 1));
  assign rq_w  = rnd_w[DW-1:EXTRA_BITS];
  assign sat_w = (rq_w[SW] != rq_w[SW-1]) ? {rq_w[SW], {(SW-1){~rq_w[SW]}}} : rq_w[SW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = tick_w ? ST_AVG : ST_IDIF;
        end
      end
      ST_AVG:  state_d = ST_BMUL;
      ST_BMUL: state_d = ST_BADD;
      ST_BADD: begin
        state_d = (n_w == '0) ? ST_POINTS : ST_CASC;
      end
      ST_CASC: begin
        if (idx_q == '0) begin
          state_d = ST_POINTS;
        end
      end
      ST_POINTS: state_d = ST_IDIF;
      ST_IDIF:   state_d = ST_IMUL;
      ST_IMUL:   state_d = ST_IADD;
      ST_IADD:   state_d = ST_DONE;
      ST_DONE: begin
        if (out_free_w) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_w = 1'b0;
    mem_we_w   = 1'b0;
    rd_addr_w  = '0;
    case (state_q)
      ST_IDLE: in_ready_w = 1'b1;
      ST_BADD: rd_addr_w  = AW'(n_w - 1'b1);
      ST_CASC: begin
        mem_we_w  = 1'b1;
        rd_addr_w = idx_q - 1'b1;
      end
      default: begin
        in_ready_w = 1'b0;
      end
    endcase
  end

  assign in_i.ready       = in_ready_w;
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_data_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_count_q <= '0;
      blend_q       <= '0;
      rate_q        <= RATE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STAGE_COUNT: stage_count_q <= cfg_data_i[STAGE_COUNT_W-1:0];
        REG_BLEND:       blend_q       <= cfg_data_i[BLEND_W-1:0];
        REG_RATE_STEP:   rate_q        <= cfg_data_i[RATE_W-1:0];
        default: begin
          stage_count_q <= stage_count_q;
        end
      endcase
    end
  end

  // control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      fa_q        <= '0;
      older_q     <= '0;
      newer_q     <= '0;
      hl_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept_w) begin
        phase_q <= tick_w ? '0 : ph_sum_w[PHASE_BITS-1:0];
      end
      if (state_q == ST_AVG) begin
        fa_q <= avg_w;
      end
      if (state_q == ST_POINTS) begin
        older_q <= newer_q;
        newer_q <= x_q;
        if (hl_q < n_w) begin
          hl_q <= n_w;
        end
      end
      if (state_q == ST_DONE && out_free_w) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept_w) begin
          x_q <= {in_i.sample_in, {EXTRA_BITS{1'b0}}};
        end
      end
      ST_AVG: begin
        opa_q <= {avg_w[IW-1], avg_w} - {x_q[IW-1], x_q};
        opb_q <= blend_q;
      end
      ST_BMUL: prod_q <= prod_w;
      ST_BADD: begin
        x_q         <= madd_w;
        blend_val_q <= madd_w;
        idx_q       <= AW'(n_w - 1'b1);
      end
      ST_CASC: begin
        x_q   <= cas_w;
        idx_q <= idx_q - 1'b1;
      end
      ST_IDIF: begin
        opa_q <= {newer_q[IW-1], newer_q} - {older_q[IW-1], older_q};
        opb_q <= phase_q;
      end
      ST_IMUL: prod_q <= prod_w;
      ST_IADD: x_q    <= madd_w;
      ST_DONE: begin
        if (out_free_w) begin
          out_data_q <= sat_w;
        end
      end
      default: begin
        x_q <= x_q;
      end
    endcase
  end

  // stage memory: one write, one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we_w) begin
      stage_mem[idx_q] <= cas_w;
    end
    rd_q <= stage_mem[rd_addr_w];
  end

  // preload mark only ever grows
  a_hl_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hl_q >= $past(hl_q))
    else $error("preload mark decreased");

  // cascade never touches a stage beyond the active count
  a_casc_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CASC) |-> (NW'(idx_q) < n_w))
    else $error("cascade index out of range");

  // a new result beat is only raised from the final sequencer step
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == ST_DONE))
    else $error("result raised outside DONE");

endmodule
